// ===== hw/rtl/tasd_pkg.sv =====
// Package: shared constants, command/status types and state encoding for the tilt detector.
`timescale 1ns / 1ps

package tasd_pkg;

   localparam int SAMPLE_BITS     = 10;
   localparam int ANGLE_FRAC_BITS = 4;
   localparam int CORDIC_STEPS    = 14;

   localparam int TABLE_FRAC  = 16;
   localparam int DELTA_W     = SAMPLE_BITS + 1;
   // CORDIC gain times sqrt(2) stays below 4
   localparam int XY_W        = DELTA_W + TABLE_FRAC + 2;
   localparam int ACC_W       = 10 + TABLE_FRAC + 1;
   localparam int STEP_W      = $clog2(CORDIC_STEPS);
   localparam int SQ_W        = 2 * SAMPLE_BITS;
   localparam int ANGLE_W     = 13;
   localparam int DIFF_W      = ANGLE_W + 2;
   localparam int ROUND_SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int TOL_W       = 13;
   localparam int ATAN_DEPTH  = 20;
   localparam int ATAN_IDX_W  = $clog2(ATAN_DEPTH);

   localparam logic [DELTA_W-1:0] MIDSCALE  = DELTA_W'(1 << (SAMPLE_BITS - 1));
   localparam logic [SQ_W:0]      MAG_LIMIT = (SQ_W + 1)'(1) << (2 * SAMPLE_BITS - 2);
   localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [ACC_W-1:0]  HALF_TURN_Q = ACC_W'(180 << TABLE_FRAC);
   localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1 << (ROUND_SHIFT - 1));

   // atan(2^-i) in degrees, 16 fractional bits
   localparam logic signed [ACC_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
      ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
      ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
      ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
      ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
      ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7)
   };

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_TOLERANCE = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(80);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_ITER,
      ST_ROUND,
      ST_WRAP,
      ST_SETTLE
   } tasd_state_type;

   typedef struct packed {
      logic              capture;
      logic              prep;
      logic              step;
      logic [STEP_W-1:0] step_idx;
      logic              round;
      logic              prime;
      logic              wrap;
      logic              commit;
      logic              emit;
   } tasd_cmd_type;

   typedef struct packed {
      logic too_big;
      logic primed;
      logic hit;
   } tasd_status_type;

endpackage

// ===== hw/rtl/tasd_ctrl.sv =====
// Controller: sequences one word through magnitude check, CORDIC, wrap and settle test.
`timescale 1ns / 1ps

module tasd_ctrl import tasd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  tasd_status_type status,
   output tasd_cmd_type    cmd
);

   tasd_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = ST_CHECK;
         ST_CHECK:  state_in = (status.primed && status.too_big) ? ST_IDLE : ST_ITER;
         ST_ITER:   if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_WRAP;
         ST_WRAP:   state_in = status.primed ? ST_SETTLE : ST_IDLE;
         ST_SETTLE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      step_in   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
         end
         ST_CHECK: begin
         end
         ST_ITER: begin
            cmd.step     = 1'b1;
            cmd.step_idx = step_ff;
            step_in      = step_ff + 1'b1;
         end
         ST_ROUND: cmd.round = 1'b1;
         ST_WRAP: begin
            cmd.prime = !status.primed;
            cmd.wrap  = status.primed;
         end
         ST_SETTLE: begin
            cmd.commit = out_free;
            cmd.emit   = out_free && status.hit;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> step_ff < STEP_W'(CORDIC_STEPS))
      else $error("CORDIC step counter out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_PREP)
      else $error("accepted word did not start processing");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("state committed while output register blocked");

   a_check_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |=> (state_ff == ST_IDLE || state_ff == ST_ITER))
      else $error("bad exit from magnitude check");

endmodule

// ===== hw/rtl/tasd_datapath.sv =====
// Datapath: sample capture, magnitude test, iterative CORDIC, wrap and settle tracking.
`timescale 1ns / 1ps

module tasd_datapath import tasd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  tasd_cmd_type           cmd,
   output tasd_status_type        status,
   input  logic [SAMPLE_BITS-1:0] x_sample,
   input  logic [SAMPLE_BITS-1:0] y_sample,
   input  logic                   button_level,
   input  logic [TOL_W-1:0]       tolerance,
   output logic [ANGLE_W-1:0]     tilt_angle
);

   logic [SAMPLE_BITS-1:0]     xs_ff, ys_ff;
   logic                       button_ff;
   logic [SQ_W-1:0]            sqx_ff, sqy_ff;
   logic                       zero_ff;
   logic signed [XY_W-1:0]     x_ff, y_ff, x_in, y_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ANGLE_W-1:0]  raw_ff;
   logic [ANGLE_W-1:0]         act_ff, act_in;
   logic [ANGLE_W-1:0]         angle_out_ff;

   logic                       primed_ff;
   logic signed [ANGLE_W-1:0]  tare_ff;
   logic [ANGLE_W-1:0]         last_ff, before_ff;
   logic                       last_button_ff;

   logic signed [DELTA_W-1:0]  dx, dy;
   logic [SAMPLE_BITS-1:0]     adx, ady;
   logic signed [XY_W-1:0]     dx_q, dy_q, sx, sy;
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [DIFF_W-1:0]   d0, d1, d2, d3;
   logic signed [ANGLE_W:0]    da, db;
   logic [ANGLE_W-1:0]         abs_a, abs_b;

   // centered samples and their magnitudes
   assign dx   = signed'({1'b0, xs_ff}) - signed'(MIDSCALE);
   assign dy   = signed'({1'b0, ys_ff}) - signed'(MIDSCALE);
   assign adx  = dx[DELTA_W-1] ? SAMPLE_BITS'(-dx) : SAMPLE_BITS'(dx);
   assign ady  = dy[DELTA_W-1] ? SAMPLE_BITS'(-dy) : SAMPLE_BITS'(dy);
   assign dx_q = XY_W'(dx) <<< TABLE_FRAC;
   assign dy_q = XY_W'(dy) <<< TABLE_FRAC;

   assign status.too_big = ({1'b0, sqx_ff} + {1'b0, sqy_ff}) >= MAG_LIMIT;
   assign status.primed  = primed_ff;

   // CORDIC rotation on atan2(-dx, -dy): x gets -dy, y gets -dx
   assign sx = x_ff >>> cmd.step_idx;
   assign sy = y_ff >>> cmd.step_idx;

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      if (cmd.prep) begin
         if (dy > 0) begin
            // left half plane: negate vector, start from +/-180
            x_in   = dy_q;
            y_in   = dx_q;
            acc_in = (dx <= 0) ? HALF_TURN_Q : -HALF_TURN_Q;
         end else begin
            x_in   = -dy_q;
            y_in   = -dx_q;
            acc_in = '0;
         end
      end else if (cmd.step) begin
         if (y_ff > 0) begin
            x_in   = x_ff + sy;
            y_in   = y_ff - sx;
            acc_in = acc_ff + ATAN_TABLE[ATAN_IDX_W'(cmd.step_idx)];
         end else begin
            x_in   = x_ff - sy;
            y_in   = y_ff + sx;
            acc_in = acc_ff - ATAN_TABLE[ATAN_IDX_W'(cmd.step_idx)];
         end
      end
   end

   assign acc_rnd = acc_ff + ROUND_BIAS;

   // difference to tare reduced into (0, full turn]
   always_comb begin
      d0 = DIFF_W'(raw_ff) - DIFF_W'(tare_ff);
      d1 = (d0 < 0) ? d0 + FULL_TURN : d0;
      d2 = (d1 < 0) ? d1 + FULL_TURN : d1;
      d3 = (d2 >= FULL_TURN) ? d2 - FULL_TURN : d2;
      act_in = (d3 == 0) ? ANGLE_W'(FULL_TURN) : ANGLE_W'(d3);
   end

   assign da    = signed'({1'b0, act_ff}) - signed'({1'b0, last_ff});
   assign db    = signed'({1'b0, before_ff}) - signed'({1'b0, last_ff});
   assign abs_a = da[ANGLE_W] ? ANGLE_W'(-da) : ANGLE_W'(da);
   assign abs_b = db[ANGLE_W] ? ANGLE_W'(-db) : ANGLE_W'(db);
   assign status.hit = (abs_a <= tolerance) && (abs_b >= tolerance);

   assign tilt_angle = angle_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         xs_ff     <= x_sample;
         ys_ff     <= y_sample;
         button_ff <= button_level;
      end
      if (cmd.prep) begin
         sqx_ff  <= adx * adx;
         sqy_ff  <= ady * ady;
         zero_ff <= (dx == 0) && (dy == 0);
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      if (cmd.round) raw_ff <= zero_ff ? '0 : acc_rnd[ROUND_SHIFT +: ANGLE_W];
      if (cmd.wrap) act_ff <= act_in;
      if (cmd.emit) angle_out_ff <= act_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff      <= 1'b0;
         tare_ff        <= '0;
         last_ff        <= '0;
         before_ff      <= '0;
         last_button_ff <= 1'b1;
      end else begin
         if (cmd.prime) begin
            tare_ff   <= raw_ff;
            primed_ff <= 1'b1;
         end
         if (cmd.commit) begin
            // falling button edge retares after this word used the old offset
            if (last_button_ff && !button_ff) tare_ff <= raw_ff;
            last_button_ff <= button_ff;
            before_ff      <= last_ff;
            last_ff        <= act_ff;
         end
      end
   end

endmodule

// ===== hw/rtl/tilt_angle_settle_detector_core.sv =====
// Top level: register port, controller and datapath of the tilt angle settle detector.
`timescale 1ns / 1ps

// Each request word carries an X/Y accelerometer pair (midscale means zero g) and
// the tare button level. The first word after reset only captures the tare angle.
// Later words whose centered vector has magnitude of midscale or more are dropped.
// Otherwise the angle is computed by a 14-step iterative vectoring CORDIC, referred
// to the tare angle and wrapped into (0, 360] degrees in 1/16 degree; a falling
// button edge retares. A response word is produced only when the angle has just
// settled within settle_tolerance (register at byte address 0, reset 80). One word
// is processed at a time: a kept word passes through accept, prepare, magnitude
// check, the CORDIC steps, round, wrap and settle test, a dropped word through
// accept, prepare and magnitude check only. A new word is accepted while a finished
// response still waits in the output register; a kept word then holds in its
// settle step until that response has been taken.
module tilt_angle_settle_detector_core import tasd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_x_sample,
   input  logic [SAMPLE_BITS-1:0] req_y_sample,
   input  logic                   req_button_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ANGLE_W-1:0]     rsp_tilt_angle,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [TOL_W-1:0] tolerance_ff, tolerance_in;
   logic             csr_wr;
   tasd_cmd_type     cmd;
   tasd_status_type  status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tolerance_in = tolerance_ff;
      if (csr_wr && csr_paddr[2] == CSR_IDX_TOLERANCE) tolerance_in = csr_pwdata[TOL_W-1:0];
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_TOLERANCE: csr_prdata = {{(32 - TOL_W){1'b0}}, tolerance_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   tasd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tasd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .x_sample     (req_x_sample),
      .y_sample     (req_y_sample),
      .button_level (req_button_level),
      .tolerance    (tolerance_ff),
      .tilt_angle   (rsp_tilt_angle)
   );

endmodule

// ===== sim/tilt_angle_settle_detector_core_tb.sv =====
// Self-checking testbench for the tilt angle settle detector: directed probes, then random settle runs.
`timescale 1ns / 1ps

module tilt_angle_settle_detector_core_tb import tasd_pkg::*;;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_NONE,
      CHK_ANGLE
   } outcome_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x;
      logic [SAMPLE_BITS-1:0] y;
      logic                   btn;
      outcome_type            chk;
      logic [ANGLE_W-1:0]     angle;
   } probe_row_type;

   localparam logic [CSR_ADDR_W-1:0] TOL_ADDR   = CSR_ADDR_W'(4 * CSR_IDX_TOLERANCE);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);
   localparam longint HALF_SCALE = 512;
   localparam longint TURN_Q4    = 360 * 16;
   localparam longint HALF_Q16   = 180 * 65536;
   localparam int     N_ITER     = 14;
   localparam int     SETTLE_WAIT = 30;
   localparam int     PROBE_COUNT = 23;

   // atan(2^-i) in degrees, 16 fractional bits
   localparam longint ATAN_Q16 [0:13] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458
   };

   localparam probe_row_type PROBES [0:PROBE_COUNT-1] = '{
      // first word only sets tare: oversized and pressed, still no response
      '{10'd0,    10'd0,    1'b0, CHK_NONE,    13'd0},
      '{10'd512,  10'd512,  1'b1, CHK_PREDICT, 13'd0},
      // falling edge retares onto the zero vector
      '{10'd512,  10'd512,  1'b0, CHK_PREDICT, 13'd0},
      '{10'd512,  10'd512,  1'b0, CHK_PREDICT, 13'd0},
      // zero angle wraps to a full turn and has just settled
      '{10'd512,  10'd512,  1'b0, CHK_ANGLE,   13'd5760},
      '{10'd0,    10'd512,  1'b0, CHK_NONE,    13'd0},
      '{10'd512,  10'd0,    1'b1, CHK_NONE,    13'd0},
      '{10'd1023, 10'd1023, 1'b1, CHK_NONE,    13'd0},
      // already steady: no new response
      '{10'd512,  10'd512,  1'b0, CHK_NONE,    13'd0},
      '{10'd1023, 10'd512,  1'b1, CHK_PREDICT, 13'd0},
      '{10'd1,    10'd512,  1'b1, CHK_PREDICT, 13'd0},
      '{10'd512,  10'd1023, 1'b1, CHK_PREDICT, 13'd0},
      '{10'd512,  10'd1,    1'b1, CHK_PREDICT, 13'd0},
      // negated vector, preset +180 vs -180
      '{10'd511,  10'd1023, 1'b1, CHK_PREDICT, 13'd0},
      '{10'd513,  10'd1023, 1'b1, CHK_PREDICT, 13'd0},
      '{10'd513,  10'd1023, 1'b1, CHK_PREDICT, 13'd0},
      // dropped word does not update the last button level
      '{10'd1023, 10'd0,    1'b0, CHK_NONE,    13'd0},
      '{10'd700,  10'd300,  1'b0, CHK_PREDICT, 13'd0},
      '{10'd700,  10'd300,  1'b0, CHK_PREDICT, 13'd0},
      '{10'd700,  10'd300,  1'b1, CHK_PREDICT, 13'd0},
      '{10'd0,    10'd1023, 1'b1, CHK_NONE,    13'd0},
      '{10'd300,  10'd700,  1'b1, CHK_PREDICT, 13'd0},
      '{10'd301,  10'd701,  1'b1, CHK_PREDICT, 13'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_x_sample = '0;
   logic [SAMPLE_BITS-1:0] req_y_sample = '0;
   logic                   req_button_level = 1'b1;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]     rsp_tilt_angle;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // predictor state
   longint tare_angle  = 0;
   bit     tare_set    = 1'b0;
   longint angle_prev  = 0;
   longint angle_prev2 = 0;
   bit     btn_prev    = 1'b1;
   longint tolerance   = 80;

   logic [ANGLE_W-1:0] angles_due [$];
   int mismatches = 0;
   int idle_pct   = 0;
   bit hold_rsp   = 1'b0;
   bit btn_state  = 1'b1;

   tilt_angle_settle_detector_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_sample     (req_x_sample),
      .req_y_sample     (req_y_sample),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tilt_angle   (rsp_tilt_angle),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   // atan2(ya, xa) in 1/16 degree, vectoring mode
   function automatic longint tilt_q4(input longint ya, input longint xa);
      longint x, y, acc, nx;
      acc = 0;
      if (xa == 0 && ya == 0) return 0;
      x = xa * 65536;
      y = ya * 65536;
      if (x < 0) begin
         acc = (y >= 0) ? HALF_Q16 : -HALF_Q16;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < N_ITER; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            acc += ATAN_Q16[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            acc -= ATAN_Q16[i];
         end
         x = nx;
      end
      return (acc + 2048) >>> 12;
   endfunction

   function automatic longint gap(input longint a, input longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   // advances the predictor by one accepted word; returns 1 when a response is due
   function automatic bit next_settled_angle(input logic [SAMPLE_BITS-1:0] xs,
                                             input logic [SAMPLE_BITS-1:0] ys,
                                             input logic btn,
                                             output logic [ANGLE_W-1:0] angle);
      longint dx, dy, raw, rel;
      bit settled;
      dx = longint'(xs) - HALF_SCALE;
      dy = longint'(ys) - HALF_SCALE;
      angle = '0;
      if (!tare_set) begin
         tare_angle = tilt_q4(-dx, -dy);
         tare_set = 1'b1;
         return 1'b0;
      end
      if (dx * dx + dy * dy >= HALF_SCALE * HALF_SCALE) return 1'b0;
      raw = tilt_q4(-dx, -dy);
      rel = (raw - tare_angle) % TURN_Q4;
      if (rel < 0) rel += TURN_Q4;
      if (rel == 0) rel = TURN_Q4;
      if (btn_prev && !btn) tare_angle = raw;
      btn_prev = btn;
      settled = gap(rel, angle_prev) <= tolerance && gap(angle_prev2, angle_prev) >= tolerance;
      angle_prev2 = angle_prev;
      angle_prev = rel;
      angle = ANGLE_W'(rel);
      return settled;
   endfunction

   task automatic offer_word(input logic [SAMPLE_BITS-1:0] xs, input logic [SAMPLE_BITS-1:0] ys,
                             input logic btn, input outcome_type chk,
                             input logic [ANGLE_W-1:0] typed);
      bit hit;
      logic [ANGLE_W-1:0] ang;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_x_sample     <= xs;
      req_y_sample     <= ys;
      req_button_level <= btn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hit = next_settled_angle(xs, ys, btn, ang);
      case (chk)
         CHK_PREDICT: if (hit) angles_due.push_back(ang);
         CHK_ANGLE:   angles_due.push_back(typed);
         default: ;
      endcase
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == TOL_ADDR) tolerance = longint'(data[TOL_W-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] want);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr  <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: csr 0x%0h expected 0x%08h, got 0x%08h", $time, addr, want, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // a dropped word can still be in flight after the last response
   task automatic drain_results();
      req_valid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_tolerance(input logic [31:0] value);
      drain_results();
      csr_write(TOL_ADDR, value);
      csr_check(TOL_ADDR, {{(32 - TOL_W){1'b0}}, value[TOL_W-1:0]});
   endtask

   // mostly steady runs around one direction, plus raw noise words
   task automatic run_phase(input int n_words, input int jitter_max, input int idle);
      int sent, run_len, bx, by, jx;
      sent = 0;
      idle_pct = idle;
      while (sent < n_words) begin
         if ($urandom_range(0, 99) < 15) begin
            offer_word(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                       1'($urandom_range(0, 1)), CHK_PREDICT, '0);
            sent++;
         end else begin
            bx = 162 + $urandom_range(0, 700);
            by = 162 + $urandom_range(0, 700);
            jx = $urandom_range(0, jitter_max);
            run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
            repeat (run_len) begin
               if ($urandom_range(0, 11) == 0) btn_state = ~btn_state;
               offer_word(SAMPLE_BITS'(bx + $urandom_range(0, 2 * jx) - jx),
                          SAMPLE_BITS'(by + $urandom_range(0, 2 * jx) - jx),
                          btn_state, CHK_PREDICT, '0);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      logic [ANGLE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angles_due.size() == 0) begin
            $display("%0t: tilt_angle expected none, got %0d", $time, rsp_tilt_angle);
            mismatches++;
         end else begin
            want = angles_due.pop_front();
            if (rsp_tilt_angle !== want) begin
               $display("%0t: tilt_angle expected %0d, got %0d", $time, want, rsp_tilt_angle);
               mismatches++;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin : receiver
      int burst;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #1_000_000;
      $display("tilt_angle_settle_detector_core_tb: done, errors");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      csr_check(TOL_ADDR, 32'd80);

      idle_pct = 25;
      for (int i = 0; i < PROBE_COUNT; i++)
         offer_word(PROBES[i].x, PROBES[i].y, PROBES[i].btn, PROBES[i].chk, PROBES[i].angle);
      drain_results();

      // no register behind the spare address
      csr_write(SPARE_ADDR, 32'd7);
      csr_check(TOL_ADDR, 32'd80);

      hold_rsp = 1'b1;
      run_phase(200, 4, 30);
      set_tolerance(32'd0);
      run_phase(200, 1, 0);
      set_tolerance(32'd5760);
      run_phase(40, 3, 20);
      set_tolerance(32'hFFFF_E040);
      run_phase(200, 6, 50);
      set_tolerance(32'($urandom_range(1, 600)));
      run_phase(200, 8, 20);
      set_tolerance(32'd1);
      run_phase(150, 0, 10);
      set_tolerance(32'd80);
      run_phase(250, 3, 0);
      drain_results();

      if (mismatches == 0 && angles_due.size() == 0)
         $display("tilt_angle_settle_detector_core_tb: done, clean");
      else
         $display("tilt_angle_settle_detector_core_tb: done, errors");
      $finish;
   end

endmodule
